// ----- design/hlt_pkg.sv -----
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants for the heartbeat liveness tracker.
// ----------------------------------------------------------------------------
package hlt_pkg;

    // Default number of tracked nodes.
    localparam int NODES_DEF = 32;

    // Field widths fixed by the record format.
    localparam int STAMP_W = 64;
    localparam int MISS_W  = 8;
    localparam int BEAT_W  = 16;
    localparam int IDX_W   = 5;
    localparam int MAP_W   = 32;
    localparam int EV_W    = 3;
    localparam int CIDX_W  = 3;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_SKIP = 3'd0;
    localparam logic [EV_W-1:0] EV_INIT = 3'd1;
    localparam logic [EV_W-1:0] EV_SEEN = 3'd2;
    localparam logic [EV_W-1:0] EV_MISS = 3'd3;
    localparam logic [EV_W-1:0] EV_GONE = 3'd4;

    // Opcodes.
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SELF_NODE    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MISS_LIMIT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BEAT_INVALID = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BEAT_NO_COMM = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BEAT_START   = 3'd4;

    // Configuration reset values.
    localparam logic [MISS_W-1:0] MISS_LIMIT_RST   = 8'd8;
    localparam logic [BEAT_W-1:0] BEAT_INVALID_RST = 16'hFFFF;
    localparam logic [BEAT_W-1:0] BEAT_NO_COMM_RST = 16'd1;
    localparam logic [BEAT_W-1:0] BEAT_START_RST   = 16'd100;

    // Saturation value of a miss counter.
    localparam logic [MISS_W-1:0] MISS_MAX = 8'hFF;

    // Configuration values the update logic needs.
    typedef struct packed {
        logic [MISS_W-1:0] miss_limit;
        logic [BEAT_W-1:0] beat_invalid;
        logic [BEAT_W-1:0] beat_no_comm;
    } t_cfg;

    // Outcome of one record update.
    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic               we;
        logic [STAMP_W-1:0] stamp;
        logic [MISS_W-1:0]  miss;
        logic               alive;
        logic               clr;
        logic [BEAT_W-1:0]  own;
        logic [BEAT_W-1:0]  shared;
    } t_upd;

endpackage

// ----- design/hlt_ram.sv -----
// ----------------------------------------------------------------------------
// hlt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/hlt_update.sv -----
// ----------------------------------------------------------------------------
// hlt_update
// Per-record update logic: miss counting, revival and multiplier lowering.
// ----------------------------------------------------------------------------
module hlt_update (
    input  logic                       i_op,
    input  logic                       i_in_range,
    input  logic [hlt_pkg::STAMP_W-1:0] i_stamp,
    input  logic [hlt_pkg::BEAT_W-1:0]  i_want,
    input  logic                       i_dism,
    input  logic [hlt_pkg::STAMP_W-1:0] i_old_stamp,
    input  logic [hlt_pkg::MISS_W-1:0]  i_old_miss,
    input  logic                       i_alive,
    input  hlt_pkg::t_cfg               i_cfg,
    input  logic [hlt_pkg::BEAT_W-1:0]  i_own,
    input  logic [hlt_pkg::BEAT_W-1:0]  i_shared,
    output hlt_pkg::t_upd               o_upd
);
    import hlt_pkg::*;

    logic [MISS_W-1:0] w_miss_inc;
    logic [MISS_W-1:0] w_miss_new;
    logic [BEAT_W-1:0] w_own_low;
    logic [BEAT_W-1:0] w_shared_min;
    logic [BEAT_W-1:0] w_shared_low;
    logic              w_lower;

    // Miss counter for an unchanged stamp; a pending dismount jumps to the limit.
    assign w_miss_inc = (i_old_miss < MISS_MAX) ? i_old_miss + 8'd1 : i_old_miss;
    assign w_miss_new = i_dism ? i_cfg.miss_limit : w_miss_inc;

    // Lowered multipliers after a fresh beat.
    assign w_lower      = (i_want != i_cfg.beat_invalid) && (i_own > i_want);
    assign w_own_low    = (i_want == '0) ? i_cfg.beat_no_comm : i_want;
    assign w_shared_min = (i_shared > w_own_low) ? w_own_low : i_shared;
    assign w_shared_low = (w_shared_min == '0) ? i_cfg.beat_no_comm : w_shared_min;

    // Decide the outcome of the record.
    always_comb begin
        o_upd        = '0;
        o_upd.ev     = EV_SKIP;
        o_upd.stamp  = i_old_stamp;
        o_upd.miss   = i_old_miss;
        o_upd.alive  = i_alive;
        o_upd.own    = i_own;
        o_upd.shared = i_shared;
        if (i_in_range) begin
            if (i_op == OP_INIT) begin
                o_upd.ev    = EV_INIT;
                o_upd.we    = 1'b1;
                o_upd.stamp = i_stamp;
            end else if (i_stamp == '0) begin
                o_upd.ev = EV_SKIP;
            end else if (i_old_stamp == i_stamp) begin
                if (i_alive) begin
                    o_upd.we   = 1'b1;
                    o_upd.miss = w_miss_new;
                    o_upd.clr  = i_dism;
                    if (w_miss_new > i_cfg.miss_limit) begin
                        o_upd.alive = 1'b0;
                        o_upd.ev    = EV_GONE;
                    end else begin
                        o_upd.ev = EV_MISS;
                    end
                end
            end else begin
                o_upd.we    = 1'b1;
                o_upd.stamp = i_stamp;
                o_upd.miss  = '0;
                o_upd.alive = 1'b1;
                o_upd.ev    = EV_SEEN;
                if (w_lower) begin
                    o_upd.own    = w_own_low;
                    o_upd.shared = w_shared_low;
                end
            end
        end
    end

endmodule

// ----- design/heartbeat_liveness_tracker_top.sv -----
// Flow: an input is accepted only in S_IDLE, when the node record RAM is read;
// in S_UPDATE, once the output is free, the record is updated, written back and
// the result registered. No new input is taken until that update is done.
// Reset: synchronous, active low; per-entry valid bits clear at once, so the
// record RAM reads as zero with no clearing pass, and the multipliers load 100.
// ----------------------------------------------------------------------------
// heartbeat_liveness_tracker_top
// Tracks node heartbeats in a record RAM and reports liveness per record.
// ----------------------------------------------------------------------------
module heartbeat_liveness_tracker_top #(
    parameter int NODES = hlt_pkg::NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [hlt_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [hlt_pkg::BEAT_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [hlt_pkg::IDX_W-1:0]   i_node_index,
    input  logic [hlt_pkg::STAMP_W-1:0] i_stamp,
    input  logic [hlt_pkg::BEAT_W-1:0]  i_wanted_beat,
    input  logic                        i_dismount_pending,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hlt_pkg::EV_W-1:0]    o_event_res,
    output logic                        o_node_alive,
    output logic [hlt_pkg::MAP_W-1:0]   o_alive_map,
    output logic                        o_dismount_clear,
    output logic [hlt_pkg::BEAT_W-1:0]  o_own_beat,
    output logic [hlt_pkg::BEAT_W-1:0]  o_shared_beat
);
    import hlt_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int RW = STAMP_W + MISS_W;

    typedef enum logic {S_IDLE, S_UPDATE} t_state;

    t_state             r_state;
    logic               r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic [BEAT_W-1:0]  r_want;
    logic               r_dism;
    logic [NODES-1:0]   r_valid;
    logic [MAP_W-1:0]   r_alive;
    logic [MAP_W-1:0]   n_alive;
    logic [MISS_W-1:0]  r_miss_limit;
    logic [BEAT_W-1:0]  r_beat_invalid;
    logic [BEAT_W-1:0]  r_beat_no_comm;
    logic [BEAT_W-1:0]  r_own;
    logic [BEAT_W-1:0]  r_shared;
    logic               r_out_valid;
    logic [EV_W-1:0]    r_event;
    logic               r_node_alive;
    logic [MAP_W-1:0]   r_alive_map;
    logic               r_clr;
    logic [BEAT_W-1:0]  r_own_out;
    logic [BEAT_W-1:0]  r_shared_out;

    logic               w_in_accept;
    logic               w_go;
    logic               w_in_range;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_addr;
    logic [RW-1:0]      w_rdata;
    logic [STAMP_W-1:0] w_old_stamp;
    logic [MISS_W-1:0]  w_old_miss;
    logic               w_ram_we;
    t_cfg               w_cfg;
    t_upd               w_upd;

    // Handshake and step control.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_go        = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);

    // Record RAM addressing: read the new node on accept, hold while stalled.
    assign w_addr     = AW'(r_idx);
    assign w_raddr    = (r_state == S_IDLE) ? AW'(i_node_index) : w_addr;
    assign w_in_range = (32'(r_idx) < NODES);
    assign w_ram_we   = w_go && w_upd.we;

    hlt_ram #(
        .WIDTH (RW),
        .DEPTH (NODES)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata ({w_upd.stamp, w_upd.miss}),
        .i_re    (1'b1),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // An entry never written reads as zero.
    assign w_old_stamp = (w_in_range && r_valid[w_addr]) ? w_rdata[RW-1:MISS_W] : '0;
    assign w_old_miss  = (w_in_range && r_valid[w_addr]) ? w_rdata[MISS_W-1:0] : '0;

    assign w_cfg.miss_limit   = r_miss_limit;
    assign w_cfg.beat_invalid = r_beat_invalid;
    assign w_cfg.beat_no_comm = r_beat_no_comm;

    hlt_update u_update (
        .i_op        (r_op),
        .i_in_range  (w_in_range),
        .i_stamp     (r_stamp),
        .i_want      (r_want),
        .i_dism      (r_dism),
        .i_old_stamp (w_old_stamp),
        .i_old_miss  (w_old_miss),
        .i_alive     (w_in_range && r_alive[r_idx]),
        .i_cfg       (w_cfg),
        .i_own       (r_own),
        .i_shared    (r_shared),
        .o_upd       (w_upd)
    );

    // Alive map after the current record.
    always_comb begin
        n_alive = r_alive;
        if (w_in_range) begin
            n_alive[r_idx] = w_upd.alive;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit   <= MISS_LIMIT_RST;
            r_beat_invalid <= BEAT_INVALID_RST;
            r_beat_no_comm <= BEAT_NO_COMM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELF_NODE:    ; // The requested multiplier arrives preselected.
                CFG_MISS_LIMIT:   r_miss_limit   <= i_cfg_data[MISS_W-1:0];
                CFG_BEAT_INVALID: r_beat_invalid <= i_cfg_data;
                CFG_BEAT_NO_COMM: r_beat_no_comm <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer, tracker state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_alive     <= '0;
            r_own       <= BEAT_START_RST;
            r_shared    <= BEAT_START_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_BEAT_START)) begin
                r_own    <= i_cfg_data;
                r_shared <= i_cfg_data;
            end
            if (w_go || (r_out_valid && i_out_ready)) begin
                r_out_valid <= w_go;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                        r_alive <= n_alive;
                        r_own    <= w_upd.own;
                        r_shared <= w_upd.shared;
                        if (w_ram_we) begin
                            r_valid[w_addr] <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Captured input fields and result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op    <= i_opcode;
            r_idx   <= i_node_index;
            r_stamp <= i_stamp;
            r_want  <= i_wanted_beat;
            r_dism  <= i_dismount_pending;
        end
        if (w_go) begin
            r_event      <= w_upd.ev;
            r_node_alive <= w_in_range && w_upd.alive;
            r_alive_map  <= n_alive;
            r_clr        <= w_upd.clr;
            r_own_out    <= w_upd.own;
            r_shared_out <= w_upd.shared;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_event;
    assign o_node_alive     = r_node_alive;
    assign o_alive_map      = r_alive_map;
    assign o_dismount_clear = r_clr;
    assign o_own_beat       = r_own_out;
    assign o_shared_beat    = r_shared_out;

`ifndef SYNTHESIS
    // An accepted transaction takes the block out of the idle state.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !o_in_ready)
        else $error("input ready stayed high after an accepted transaction");

    // Only defined event codes leave the block.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= EV_GONE))
        else $error("undefined event code on the output");

    // A consumed dismount only comes with a miss or a removal.
    a_clear_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dismount_clear) |->
            ((o_event_res == EV_MISS) || (o_event_res == EV_GONE)))
        else $error("dismount cleared without a missed beat");

    // A seen beat leaves the node alive, a removal leaves it dead.
    a_alive_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_event_res == EV_SEEN) || (o_event_res == EV_GONE))) |->
            (o_node_alive == (o_event_res == EV_SEEN)))
        else $error("node alive bit disagrees with the event");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heartbeat liveness tracker. Heartbeat records
// go through the input channel with random gaps and the reports are taken
// with random back-pressure. Every accepted transaction is run through a
// behavioral copy of the tracker, and each report is compared field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;
    import hlt_pkg::*;

    localparam int NODE_CNT      = NODES_DEF;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    // One heartbeat record as offered on the input channel.
    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   node;
        logic [STAMP_W-1:0] stamp;
        logic [BEAT_W-1:0]  want;
        logic               dismount;
    } t_beat_record;

    // One report as delivered on the output channel.
    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic              alive;
        logic [MAP_W-1:0]  map;
        logic              clr;
        logic [BEAT_W-1:0] own;
        logic [BEAT_W-1:0] shared;
    } t_beat_report;

    // Behavioral copy of the tracker plus the queue of reports still due.
    class liveness_scoreboard;
        logic [IDX_W-1:0]   self_node;
        logic [MISS_W-1:0]  miss_limit;
        logic [BEAT_W-1:0]  beat_invalid;
        logic [BEAT_W-1:0]  beat_no_comm;
        logic [STAMP_W-1:0] stored_stamp [NODE_CNT];
        logic [MISS_W-1:0]  misses [NODE_CNT];
        logic [MAP_W-1:0]   alive_nodes;
        logic [BEAT_W-1:0]  own_beat;
        logic [BEAT_W-1:0]  shared_beat;
        t_beat_report       awaited_reports [$];
        int                 faults;

        function new();
            self_node    = '0;
            miss_limit   = MISS_LIMIT_RST;
            beat_invalid = BEAT_INVALID_RST;
            beat_no_comm = BEAT_NO_COMM_RST;
            own_beat     = BEAT_START_RST;
            shared_beat  = BEAT_START_RST;
            alive_nodes  = '0;
            faults       = 0;
            foreach (stored_stamp[n]) begin
                stored_stamp[n] = '0;
                misses[n]       = '0;
            end
        endfunction

        // A write to the start multiplier also reloads both multipliers.
        function void set_reg(logic [CIDX_W-1:0] idx, logic [BEAT_W-1:0] data);
            case (idx)
                CFG_SELF_NODE:    self_node    = data[IDX_W-1:0];
                CFG_MISS_LIMIT:   miss_limit   = data[MISS_W-1:0];
                CFG_BEAT_INVALID: beat_invalid = data;
                CFG_BEAT_NO_COMM: beat_no_comm = data;
                CFG_BEAT_START: begin
                    own_beat    = data;
                    shared_beat = data;
                end
                default: ;
            endcase
        endfunction

        // Applies one record to the tracked state and returns its report.
        function t_beat_report project_report(t_beat_record r);
            t_beat_report rep;
            rep.ev  = EV_SKIP;
            rep.clr = 1'b0;
            if (r.op == OP_INIT) begin
                stored_stamp[r.node] = r.stamp;
                rep.ev = EV_INIT;
            end else if (r.stamp == '0) begin
                rep.ev = EV_SKIP;
            end else if (stored_stamp[r.node] == r.stamp) begin
                // Unchanged stamp only matters for a node that is alive.
                if (alive_nodes[r.node]) begin
                    if (r.dismount) begin
                        misses[r.node] = miss_limit;
                        rep.clr = 1'b1;
                    end else if (misses[r.node] != MISS_MAX) begin
                        misses[r.node] = misses[r.node] + 1'b1;
                    end
                    if (misses[r.node] > miss_limit) begin
                        alive_nodes[r.node] = 1'b0;
                        rep.ev = EV_GONE;
                    end else begin
                        rep.ev = EV_MISS;
                    end
                end
            end else begin
                misses[r.node]       = '0;
                stored_stamp[r.node] = r.stamp;
                alive_nodes[r.node]  = 1'b1;
                rep.ev = EV_SEEN;
                // A fresh beat may lower our multiplier toward the request.
                if (r.want != beat_invalid && own_beat > r.want) begin
                    own_beat = (r.want == '0) ? beat_no_comm : r.want;
                    if (shared_beat > own_beat)
                        shared_beat = own_beat;
                    if (shared_beat == '0)
                        shared_beat = beat_no_comm;
                end
            end
            rep.alive  = alive_nodes[r.node];
            rep.map    = alive_nodes;
            rep.own    = own_beat;
            rep.shared = shared_beat;
            return rep;
        endfunction

        function void note_record(t_beat_record r);
            awaited_reports.push_back(project_report(r));
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= REPORT_MAX)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_report(t_beat_report got);
            t_beat_report want_rep;
            if (awaited_reports.size() == 0) begin
                flag($sformatf("report with nothing pending: ev=%0d map=%h", got.ev, got.map));
                return;
            end
            want_rep = awaited_reports.pop_front();
            if (got.ev !== want_rep.ev || got.alive !== want_rep.alive ||
                got.map !== want_rep.map || got.clr !== want_rep.clr ||
                got.own !== want_rep.own || got.shared !== want_rep.shared)
                flag($sformatf({"report mismatch: expected ev=%0d alive=%b map=%h clr=%b ",
                                "own=%0d shared=%0d, got ev=%0d alive=%b map=%h clr=%b ",
                                "own=%0d shared=%0d"},
                               want_rep.ev, want_rep.alive, want_rep.map, want_rep.clr,
                               want_rep.own, want_rep.shared, got.ev, got.alive, got.map,
                               got.clr, got.own, got.shared));
        endfunction

        function int outstanding();
            return awaited_reports.size();
        endfunction

        // Any prediction still queued at the end is a missing report.
        function void flush_check();
            t_beat_report left;
            while (awaited_reports.size() != 0) begin
                left = awaited_reports.pop_front();
                flag($sformatf("report never delivered: ev=%0d map=%h", left.ev, left.map));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CIDX_W-1:0]    i_cfg_index;
    logic [BEAT_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_opcode;
    logic [IDX_W-1:0]     i_node_index;
    logic [STAMP_W-1:0]   i_stamp;
    logic [BEAT_W-1:0]    i_wanted_beat;
    logic                 i_dismount_pending;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [EV_W-1:0]      o_event_res;
    logic                 o_node_alive;
    logic [MAP_W-1:0]     o_alive_map;
    logic                 o_dismount_clear;
    logic [BEAT_W-1:0]    o_own_beat;
    logic [BEAT_W-1:0]    o_shared_beat;

    liveness_scoreboard   board = new();

    // Stamp each node holds in the tracker, as the driver sees it.
    logic [STAMP_W-1:0]   published [NODE_CNT];
    logic [BEAT_W-1:0]    cur_invalid;
    logic                 in_calm;
    logic                 out_calm;
    int                   hold_asks;
    int                   hold_grants;

    heartbeat_liveness_tracker_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_node_index       (i_node_index),
        .i_stamp            (i_stamp),
        .i_wanted_beat      (i_wanted_beat),
        .i_dismount_pending (i_dismount_pending),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_event_res        (o_event_res),
        .o_node_alive       (o_node_alive),
        .o_alive_map        (o_alive_map),
        .o_dismount_clear   (o_dismount_clear),
        .o_own_beat         (o_own_beat),
        .o_shared_beat      (o_shared_beat)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Each accepted input transaction is predicted at once.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_record('{op: i_opcode, node: i_node_index, stamp: i_stamp,
                                want: i_wanted_beat, dismount: i_dismount_pending});
    end

    // Each accepted output transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_report('{ev: o_event_res, alive: o_node_alive, map: o_alive_map,
                                 clr: o_dismount_clear, own: o_own_beat,
                                 shared: o_shared_beat});
    end

    // Result sink: random back-pressure, calm stretches and one long hold-off.
    initial begin : result_sink
        int hold_left;
        hold_left   = 0;
        hold_grants = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_grants != hold_asks) begin
                hold_left   = HOLD_CYCLES;
                hold_grants = hold_asks;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (out_calm) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = ($urandom_range(99) >= 19);
            end
        end
    end

    // Offers one record, possibly after an idle gap, and waits for acceptance.
    task automatic offer(input t_beat_record r);
        int gap;
        if (!in_calm && $urandom_range(99) < 19) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (r.op == OP_INIT || r.stamp != '0)
            published[r.node] = r.stamp;
        @(negedge i_clk);
        i_in_valid         = 1'b1;
        i_opcode           = r.op;
        i_node_index       = r.node;
        i_stamp            = r.stamp;
        i_wanted_beat      = r.want;
        i_dismount_pending = r.dismount;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
    endtask

    // Stops offering and waits until every predicted report has come back.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_reg(input logic [CIDX_W-1:0] idx, input logic [BEAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // Writes every register; only called while the tracker is idle.
    task automatic configure(input logic [IDX_W-1:0] self_idx, input logic [MISS_W-1:0] limit,
                             input logic [BEAT_W-1:0] invalid, input logic [BEAT_W-1:0] no_comm,
                             input logic [BEAT_W-1:0] start);
        load_reg(CFG_SELF_NODE, BEAT_W'(self_idx));
        load_reg(CFG_MISS_LIMIT, BEAT_W'(limit));
        load_reg(CFG_BEAT_INVALID, invalid);
        load_reg(CFG_BEAT_NO_COMM, no_comm);
        load_reg(CFG_BEAT_START, start);
        cur_invalid = invalid;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_beat_record make_record(logic op, logic [IDX_W-1:0] node,
                                                 logic [STAMP_W-1:0] stamp,
                                                 logic [BEAT_W-1:0] want, logic dismount);
        return '{op: op, node: node, stamp: stamp, want: want, dismount: dismount};
    endfunction

    // Random record: mostly a small window of nodes, so that misses pile up,
    // with repeated stamps about half the time.
    function automatic t_beat_record draw_record(logic [IDX_W-1:0] base);
        t_beat_record r;
        int roll;
        r.node = ($urandom_range(99) < 70) ? IDX_W'(base + $urandom_range(0, 2))
                                           : IDX_W'($urandom_range(0, NODE_CNT - 1));
        r.op       = ($urandom_range(99) < 8) ? OP_INIT : OP_SCAN;
        r.dismount = ($urandom_range(99) < 10);
        roll = $urandom_range(99);
        if (roll < 6)
            r.stamp = '0;
        else if (roll < 56)
            r.stamp = published[r.node];
        else if (roll < 70)
            r.stamp = STAMP_W'($urandom_range(1, 15));
        else
            r.stamp = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 15)
            r.want = cur_invalid;
        else if (roll < 25)
            r.want = '0;
        else if (roll < 32)
            r.want = '1;
        else if (roll < 62)
            r.want = BEAT_W'($urandom);
        else
            r.want = BEAT_W'($urandom_range(0, 400));
        return r;
    endfunction

    initial begin : stimulus
        logic [IDX_W-1:0] base;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_SELF_NODE;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_opcode           = OP_INIT;
        i_node_index       = '0;
        i_stamp            = '0;
        i_wanted_beat      = '0;
        i_dismount_pending = 1'b0;
        in_calm            = 1'b0;
        out_calm           = 1'b0;
        hold_asks          = 0;
        cur_invalid        = BEAT_INVALID_RST;
        foreach (published[n])
            published[n] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with a miss limit of one so removals come quickly.
        configure(5'd31, 8'd1, 16'd50, 16'd7, 16'd1000);
        offer(make_record(OP_SCAN, 5'd0, 64'd0, 16'd10, 1'b1));     // zero stamp skips
        offer(make_record(OP_SCAN, 5'd0, 64'd5, 16'd50, 1'b0));     // request is invalid
        offer(make_record(OP_SCAN, 5'd31, '1, 16'hFFFF, 1'b0));
        offer(make_record(OP_SCAN, 5'd31, '1, 16'd0, 1'b0));        // first miss
        offer(make_record(OP_SCAN, 5'd31, '1, 16'd0, 1'b0));        // removed
        offer(make_record(OP_SCAN, 5'd31, '1, 16'd0, 1'b1));        // dead node, flag ignored
        offer(make_record(OP_INIT, 5'd31, 64'h1234, 16'd0, 1'b0));
        offer(make_record(OP_SCAN, 5'd31, 64'h1234, 16'd0, 1'b0));  // unchanged, still dead
        offer(make_record(OP_SCAN, 5'd31, 64'h1235, 16'd300, 1'b0));
        offer(make_record(OP_SCAN, 5'd31, 64'h1235, 16'd0, 1'b1));  // dismount sets the limit
        offer(make_record(OP_SCAN, 5'd31, 64'h1235, 16'd0, 1'b1));
        offer(make_record(OP_SCAN, 5'd31, 64'h1235, 16'd0, 1'b0));  // over the limit
        offer(make_record(OP_SCAN, 5'd10, 64'd1, 16'd0, 1'b0));     // zero request lowers to the no-comm value
        offer(make_record(OP_SCAN, 5'd21, 64'd2, 16'd3, 1'b0));
        offer(make_record(OP_SCAN, 5'd0, 64'd6, 16'd0, 1'b0));      // own rises, shared holds
        offer(make_record(OP_INIT, 5'd21, 64'd0, 16'd0, 1'b0));
        offer(make_record(OP_SCAN, 5'd21, 64'd2, 16'hFFFF, 1'b0));
        offer(make_record(OP_INIT, 5'd5, '1, 16'd0, 1'b1));

        // Saturating counter: a limit of 255 never removes a node.
        settle();
        configure(5'd0, 8'd255, 16'hFFFF, 16'd0, 16'hFFFF);
        offer(make_record(OP_SCAN, 5'd3, 64'd9, 16'd0, 1'b0));      // no-comm value of zero
        offer(make_record(OP_SCAN, 5'd3, 64'd9, 16'd0, 1'b1));
        offer(make_record(OP_SCAN, 5'd3, 64'd9, 16'd0, 1'b0));
        offer(make_record(OP_SCAN, 5'd3, 64'd9, 16'd0, 1'b0));

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: configure(5'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF);
                1: configure(5'd17, 8'd3, 16'hFFFF, 16'hFFFF, 16'd200);
                2: configure(5'd31, 8'd254, 16'd1234, 16'd1, 16'd0);
                3: configure(5'd9, 8'd255, 16'hFFFF, 16'd5, 16'hFFFF);
                default: configure(IDX_W'($urandom), MISS_W'($urandom_range(0, 6)),
                                   BEAT_W'($urandom_range(0, 400)), BEAT_W'($urandom),
                                   BEAT_W'($urandom));
            endcase
            base = IDX_W'($urandom_range(0, NODE_CNT - 1));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Long receiver hold-off while records keep coming.
                if (ph == 1 && k == 40)
                    hold_asks++;
                // Sender pause until every report is back.
                if (ph == 2 && k == 75)
                    settle();
                in_calm  = (ph == 3 && k < 120);
                out_calm = in_calm;
                offer(draw_record(base));
            end
        end

        settle();
        board.flush_check();
        if (board.faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
